[design/ccd_pkg.sv]
`default_nettype none
package ccd_pkg;

    localparam int DigitWidth = 4;
    localparam int CountWidth = 6;
    localparam int AmountWidth = 7;
    localparam int PhaseWidth = 2;
    localparam int DenomWidth = 4;
    localparam int PiecesWidth = 3;
    localparam int ButtonWidth = 5;
    localparam int StepWidth = 4;
    localparam int UcodeDepth = 11;
    localparam int AddrWidth = 4;
    localparam int DataWidth = 32;

    localparam logic [CountWidth-1:0] CountMax = 6'd63;
    localparam logic [CountWidth-1:0] IdleLimitReset = 6'd50;
    localparam logic [CountWidth-1:0] HoldLimitReset = 6'd30;
    localparam logic [CountWidth-1:0] ConfirmLimitReset = 6'd30;

    // button bit positions
    localparam int BtnTens = 4;
    localparam int BtnUnits = 3;
    localparam int BtnDecimal = 2;
    localparam int BtnTenths = 1;
    localparam int BtnHundredths = 0;

    localparam logic [PhaseWidth-1:0] PhaseEntering = 2'd0;
    localparam logic [PhaseWidth-1:0] PhaseConfirmed = 2'd1;
    localparam logic [PhaseWidth-1:0] PhaseDenom = 2'd2;

    // first index of the hundredths denominations
    localparam logic [DenomWidth-1:0] FirstCentDenom = 4'd4;

    typedef enum logic [1:0] {
        OP_POLL,
        OP_SHOW,
        OP_DENOM
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [DenomWidth-1:0] denom;
        logic [StepWidth-1:0]  next_step;
        logic [StepWidth-1:0]  jump_step;
    } ucode_t;

    typedef struct packed {
        logic                  accept;
        logic                  show_fire;
        logic                  denom_adv;
        logic                  denom_fire;
        logic [DenomWidth-1:0] denom;
    } ctrl_t;

    typedef struct packed {
        logic brk;
        logic n_zero;
        logic rem_zero;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [PhaseWidth-1:0]  phase;
        logic [AmountWidth-1:0] whole;
        logic [AmountWidth-1:0] cent;
        logic                   brk;
    } poll_t;

    typedef struct packed {
        logic [CountWidth-1:0] idle_limit;
        logic [CountWidth-1:0] hold_limit;
        logic [CountWidth-1:0] confirm_limit;
    } cfg_t;

    // microprogram: take a poll, show it, then on a breakdown one step per denomination
    function automatic ucode_t ucode_word(input logic [StepWidth-1:0] step);
        ucode_t w;
        w = '{op: OP_POLL, denom: 4'd0, next_step: 4'd1, jump_step: 4'd1};
        unique case (step)
            4'd0:    w = '{op: OP_POLL,  denom: 4'd0, next_step: 4'd1,  jump_step: 4'd1};
            4'd1:    w = '{op: OP_SHOW,  denom: 4'd0, next_step: 4'd2,  jump_step: 4'd0};
            4'd2:    w = '{op: OP_DENOM, denom: 4'd0, next_step: 4'd3,  jump_step: 4'd0};
            4'd3:    w = '{op: OP_DENOM, denom: 4'd1, next_step: 4'd4,  jump_step: 4'd0};
            4'd4:    w = '{op: OP_DENOM, denom: 4'd2, next_step: 4'd5,  jump_step: 4'd0};
            4'd5:    w = '{op: OP_DENOM, denom: 4'd3, next_step: 4'd6,  jump_step: 4'd0};
            4'd6:    w = '{op: OP_DENOM, denom: 4'd4, next_step: 4'd7,  jump_step: 4'd0};
            4'd7:    w = '{op: OP_DENOM, denom: 4'd5, next_step: 4'd8,  jump_step: 4'd0};
            4'd8:    w = '{op: OP_DENOM, denom: 4'd6, next_step: 4'd9,  jump_step: 4'd0};
            4'd9:    w = '{op: OP_DENOM, denom: 4'd7, next_step: 4'd10, jump_step: 4'd0};
            4'd10:   w = '{op: OP_DENOM, denom: 4'd8, next_step: 4'd0,  jump_step: 4'd0};
            default: w = '{op: OP_POLL,  denom: 4'd0, next_step: 4'd1,  jump_step: 4'd1};
        endcase
        return w;
    endfunction

    function automatic logic [8:0] denom_value(input logic [DenomWidth-1:0] idx);
        logic [8:0] d;
        d = 9'd1;
        unique case (idx)
            4'd0:    d = 9'd20;
            4'd1:    d = 9'd10;
            4'd2:    d = 9'd5;
            4'd3:    d = 9'd1;
            4'd4:    d = 9'd50;
            4'd5:    d = 9'd25;
            4'd6:    d = 9'd10;
            4'd7:    d = 9'd5;
            default: d = 9'd1;
        endcase
        return d;
    endfunction

    function automatic logic [DigitWidth-1:0] step_digit(input logic [DigitWidth-1:0] d);
        return (d >= 4'd9) ? 4'd0 : d + 4'd1;
    endfunction

    function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] c);
        return (c == CountMax) ? c : c + 6'd1;
    endfunction

endpackage
`default_nettype wire

[design/coin_change_entry_dispenser.sv]
`default_nettype none
// Amount entry from five polled buttons with a greedy breakdown into 20, 10, 5 and 1 whole
// units and 50, 25, 10, 5 and 1 hundredths. A microprogram of eleven steps runs the block:
// one step takes the poll and updates the digits and counters, the next loads its result
// into the output register once that register is free. A breakdown poll then runs
// one step per denomination, up to nine more, and ends early once nothing is left, for
// up to ten results in all. Each result waits in the output register while the
// next request is already taken. Registers: idle_limit at 0x0, hold_limit at 0x4,
// confirm_limit at 0x8, six bits each; write them only while the block is idle.
module coin_change_entry_dispenser (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ccd_pkg::AddrWidth-1:0]     paddr,
    input  wire logic [ccd_pkg::DataWidth-1:0]     pwdata,
    output logic [ccd_pkg::DataWidth-1:0]          prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [ccd_pkg::ButtonWidth-1:0]   buttons_pressed,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [ccd_pkg::PhaseWidth-1:0]         phase,
    output logic [ccd_pkg::AmountWidth-1:0]        whole_part,
    output logic [ccd_pkg::AmountWidth-1:0]        cent_part,
    output logic [ccd_pkg::DenomWidth-1:0]         denom_index,
    output logic [ccd_pkg::PiecesWidth-1:0]        denom_count,
    output logic                                   last
);

    localparam logic [1:0] RegIdleLimit = 2'd0;
    localparam logic [1:0] RegHoldLimit = 2'd1;
    localparam logic [1:0] RegConfirmLimit = 2'd2;

    logic [ccd_pkg::CountWidth-1:0] idle_limit_reg, hold_limit_reg, confirm_limit_reg;
    logic                           cfg_write;
    logic [1:0]                     reg_index;
    ccd_pkg::cfg_t                  cfg;
    ccd_pkg::ctrl_t                 ctrl;
    ccd_pkg::status_t               status;
    ccd_pkg::poll_t                 poll;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= ccd_pkg::IdleLimitReset;
            hold_limit_reg <= ccd_pkg::HoldLimitReset;
            confirm_limit_reg <= ccd_pkg::ConfirmLimitReset;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                RegIdleLimit:    idle_limit_reg <= pwdata[ccd_pkg::CountWidth-1:0];
                RegHoldLimit:    hold_limit_reg <= pwdata[ccd_pkg::CountWidth-1:0];
                RegConfirmLimit: confirm_limit_reg <= pwdata[ccd_pkg::CountWidth-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            RegIdleLimit:    prdata = ccd_pkg::DataWidth'(idle_limit_reg);
            RegHoldLimit:    prdata = ccd_pkg::DataWidth'(hold_limit_reg);
            RegConfirmLimit: prdata = ccd_pkg::DataWidth'(confirm_limit_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.idle_limit = idle_limit_reg;
    assign cfg.hold_limit = hold_limit_reg;
    assign cfg.confirm_limit = confirm_limit_reg;

    ccd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    ccd_entry u_entry (
        .clk             (clk),
        .rst_n           (rst_n),
        .buttons_pressed (buttons_pressed),
        .accept          (ctrl.accept),
        .cfg             (cfg),
        .poll            (poll)
    );

    ccd_split u_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .poll        (poll),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .phase       (phase),
        .whole_part  (whole_part),
        .cent_part   (cent_part),
        .denom_index (denom_index),
        .denom_count (denom_count),
        .last        (last)
    );

endmodule
`default_nettype wire

[design/ccd_seq.sv]
`default_nettype none
module ccd_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ccd_pkg::status_t status,
    output ccd_pkg::ctrl_t       ctrl
);

    logic [ccd_pkg::StepWidth-1:0] step_reg;
    logic [ccd_pkg::StepWidth-1:0] step_next;
    ccd_pkg::ucode_t               word;

    assign word = ccd_pkg::ucode_word(step_reg);
    assign in_ready = (word.op == ccd_pkg::OP_POLL);

    always_comb
    begin
        step_next = step_reg;
        ctrl = '0;
        ctrl.denom = word.denom;
        unique case (word.op)
            ccd_pkg::OP_POLL:
            begin
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    step_next = word.next_step;
                end
            end
            ccd_pkg::OP_SHOW:
            begin
                if (status.out_free)
                begin
                    ctrl.show_fire = 1'b1;
                    step_next = status.brk ? word.next_step : word.jump_step;
                end
            end
            ccd_pkg::OP_DENOM:
            begin
                // zero pieces of this denomination: skip without a line
                if (status.n_zero)
                begin
                    ctrl.denom_adv = 1'b1;
                    step_next = word.next_step;
                end
                else if (status.out_free)
                begin
                    ctrl.denom_adv = 1'b1;
                    ctrl.denom_fire = 1'b1;
                    step_next = status.rem_zero ? word.jump_step : word.next_step;
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < ccd_pkg::StepWidth'(ccd_pkg::UcodeDepth))
        else $error("step counter left the microprogram");

    a_accept_then_show: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.accept |=> (word.op == ccd_pkg::OP_SHOW))
        else $error("poll not followed by show step");

    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.accept, ctrl.show_fire, ctrl.denom_fire}))
        else $error("more than one sequencer strobe");

endmodule
`default_nettype wire

[design/ccd_entry.sv]
`default_nettype none
module ccd_entry (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [ccd_pkg::ButtonWidth-1:0]   buttons_pressed,
    input  wire logic                              accept,
    input  wire ccd_pkg::cfg_t                     cfg,
    output ccd_pkg::poll_t                         poll
);

    logic [ccd_pkg::DigitWidth-1:0] tens_reg, units_reg, tenths_reg, hund_reg;
    logic [ccd_pkg::DigitWidth-1:0] tens_next, units_next, tenths_next, hund_next;
    logic                           frac_reg, frac_next;
    logic [ccd_pkg::CountWidth-1:0] idle_reg, hold_reg, confirm_reg;
    logic [ccd_pkg::CountWidth-1:0] idle_next, hold_next, confirm_next;
    logic                           open_input;
    logic                           zero_after;
    logic [ccd_pkg::CountWidth-1:0] idle_mid;

    always_comb
    begin
        tens_next = tens_reg;
        units_next = units_reg;
        tenths_next = tenths_reg;
        hund_next = hund_reg;
        frac_next = frac_reg;
        idle_mid = idle_reg;
        confirm_next = confirm_reg;
        idle_next = idle_reg;

        open_input = (idle_reg < cfg.idle_limit) ||
                     ((tens_reg == '0) && (units_reg == '0) &&
                      (tenths_reg == '0) && (hund_reg == '0));

        if (open_input)
        begin
            priority if (buttons_pressed[ccd_pkg::BtnTens])
            begin
                tens_next = ccd_pkg::step_digit(tens_reg);
                idle_mid = '0;
            end
            else if (buttons_pressed[ccd_pkg::BtnUnits])
            begin
                units_next = ccd_pkg::step_digit(units_reg);
                idle_mid = '0;
            end
            else if (buttons_pressed[ccd_pkg::BtnDecimal])
            begin
                frac_next = 1'b1;
                idle_mid = '0;
            end
            else if (buttons_pressed[ccd_pkg::BtnTenths] && frac_reg)
            begin
                tenths_next = ccd_pkg::step_digit(tenths_reg);
                idle_mid = '0;
            end
            else if (buttons_pressed[ccd_pkg::BtnHundredths] && frac_reg)
            begin
                hund_next = ccd_pkg::step_digit(hund_reg);
                idle_mid = '0;
            end
        end

        hold_next = buttons_pressed[ccd_pkg::BtnDecimal] ? ccd_pkg::sat_inc(hold_reg) : '0;
        // long hold of the decimal button reopens input
        if (hold_next > cfg.hold_limit)
        begin
            idle_mid = '0;
        end

        zero_after = (tens_next == '0) && (units_next == '0) &&
                     (tenths_next == '0) && (hund_next == '0);

        poll.whole = ccd_pkg::AmountWidth'(tens_next) * 7'd10 +
                     ccd_pkg::AmountWidth'(units_next);
        poll.cent = ccd_pkg::AmountWidth'(tenths_next) * 7'd10 +
                    ccd_pkg::AmountWidth'(hund_next);
        poll.brk = 1'b0;
        poll.phase = ccd_pkg::PhaseEntering;

        if ((idle_mid > cfg.idle_limit) && !zero_after)
        begin
            poll.phase = ccd_pkg::PhaseConfirmed;
            confirm_next = ccd_pkg::sat_inc(confirm_reg);
            idle_next = ccd_pkg::sat_inc(idle_mid);
            if (confirm_next > cfg.confirm_limit)
            begin
                poll.brk = 1'b1;
            end
        end
        else
        begin
            confirm_next = '0;
            idle_next = ccd_pkg::sat_inc(idle_mid);
        end

        // breakdown empties everything
        if (poll.brk)
        begin
            tens_next = '0;
            units_next = '0;
            tenths_next = '0;
            hund_next = '0;
            frac_next = 1'b0;
            idle_next = '0;
            hold_next = '0;
            confirm_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tens_reg <= '0;
            units_reg <= '0;
            tenths_reg <= '0;
            hund_reg <= '0;
            frac_reg <= 1'b0;
            idle_reg <= '0;
            hold_reg <= '0;
            confirm_reg <= '0;
        end
        else if (accept)
        begin
            tens_reg <= tens_next;
            units_reg <= units_next;
            tenths_reg <= tenths_next;
            hund_reg <= hund_next;
            frac_reg <= frac_next;
            idle_reg <= idle_next;
            hold_reg <= hold_next;
            confirm_reg <= confirm_next;
        end
    end

    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        (tens_reg <= 4'd9) && (units_reg <= 4'd9) &&
        (tenths_reg <= 4'd9) && (hund_reg <= 4'd9))
        else $error("digit out of decimal range");

    a_fraction_locked: assert property (@(posedge clk) disable iff (!rst_n)
        !frac_reg |-> ((tenths_reg == '0) && (hund_reg == '0)))
        else $error("fraction digits moved while locked");

endmodule
`default_nettype wire

[design/ccd_split.sv]
`default_nettype none
module ccd_split (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ccd_pkg::ctrl_t                    ctrl,
    input  wire ccd_pkg::poll_t                    poll,
    output ccd_pkg::status_t                       status,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [ccd_pkg::PhaseWidth-1:0]         phase,
    output logic [ccd_pkg::AmountWidth-1:0]        whole_part,
    output logic [ccd_pkg::AmountWidth-1:0]        cent_part,
    output logic [ccd_pkg::DenomWidth-1:0]         denom_index,
    output logic [ccd_pkg::PiecesWidth-1:0]        denom_count,
    output logic                                   last
);

    logic [ccd_pkg::AmountWidth-1:0] whole_reg, cent_reg;
    logic [ccd_pkg::PhaseWidth-1:0]  work_phase_reg;
    logic                            brk_reg;
    logic                            out_valid_reg;
    logic [ccd_pkg::PhaseWidth-1:0]  phase_reg;
    logic [ccd_pkg::AmountWidth-1:0] whole_out_reg, cent_out_reg;
    logic [ccd_pkg::DenomWidth-1:0]  denom_out_reg;
    logic [ccd_pkg::PiecesWidth-1:0] count_out_reg;
    logic                            last_reg;

    logic                            is_cent;
    logic [8:0]                      value;
    logic [8:0]                      denom;
    logic [ccd_pkg::PiecesWidth-1:0] pieces;
    logic [8:0]                      taken;
    logic [8:0]                      rem;
    logic [ccd_pkg::AmountWidth-1:0] whole_next, cent_next;

    // one denomination: at most four pieces fit what greedy leaves over
    always_comb
    begin
        is_cent = (ctrl.denom >= ccd_pkg::FirstCentDenom);
        value = is_cent ? 9'(cent_reg) : 9'(whole_reg);
        denom = ccd_pkg::denom_value(ctrl.denom);
        priority if (value >= denom * 9'd4)
        begin
            pieces = 3'd4;
        end
        else if (value >= denom * 9'd3)
        begin
            pieces = 3'd3;
        end
        else if (value >= denom * 9'd2)
        begin
            pieces = 3'd2;
        end
        else if (value >= denom)
        begin
            pieces = 3'd1;
        end
        else
        begin
            pieces = 3'd0;
        end
        taken = denom * 9'(pieces);
        rem = value - taken;
        whole_next = is_cent ? whole_reg : rem[ccd_pkg::AmountWidth-1:0];
        cent_next = is_cent ? rem[ccd_pkg::AmountWidth-1:0] : cent_reg;
    end

    assign status.brk = brk_reg;
    assign status.n_zero = (pieces == '0);
    assign status.rem_zero = (whole_next == '0) && (cent_next == '0);
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            whole_reg <= poll.whole;
            cent_reg <= poll.cent;
            work_phase_reg <= poll.phase;
        end
        else if (ctrl.denom_adv)
        begin
            whole_reg <= whole_next;
            cent_reg <= cent_next;
        end

        if (ctrl.show_fire)
        begin
            phase_reg <= work_phase_reg;
            whole_out_reg <= whole_reg;
            cent_out_reg <= cent_reg;
            denom_out_reg <= '0;
            count_out_reg <= '0;
            last_reg <= !brk_reg;
        end
        else if (ctrl.denom_fire)
        begin
            phase_reg <= ccd_pkg::PhaseDenom;
            whole_out_reg <= whole_next;
            cent_out_reg <= cent_next;
            denom_out_reg <= ctrl.denom;
            count_out_reg <= pieces;
            last_reg <= status.rem_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brk_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.accept)
            begin
                brk_reg <= poll.brk;
            end
            if (ctrl.show_fire || ctrl.denom_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign phase = phase_reg;
    assign whole_part = whole_out_reg;
    assign cent_part = cent_out_reg;
    assign denom_index = denom_out_reg;
    assign denom_count = count_out_reg;
    assign last = last_reg;

    a_line_has_pieces: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (phase_reg == ccd_pkg::PhaseDenom)) |-> (count_out_reg != '0))
        else $error("denomination line with no pieces");

    a_last_line_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg && (phase_reg == ccd_pkg::PhaseDenom)) |->
        ((whole_out_reg == '0) && (cent_out_reg == '0)))
        else $error("final line leaves an amount over");

    a_fire_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.show_fire || ctrl.denom_fire) |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken one");

endmodule
`default_nettype wire

[tb/sv/coin_change_entry_dispenser_tb.sv]
`timescale 1ns / 1ps

module coin_change_entry_dispenser_tb;

    localparam logic [ccd_pkg::AddrWidth-1:0] REG_IDLE_LIMIT = 4'h0;
    localparam logic [ccd_pkg::AddrWidth-1:0] REG_HOLD_LIMIT = 4'h4;
    localparam logic [ccd_pkg::AddrWidth-1:0] REG_CONFIRM_LIMIT = 4'h8;
    localparam logic [ccd_pkg::AddrWidth-1:0] REG_UNUSED = 4'hC;

    localparam logic [ccd_pkg::ButtonWidth-1:0] NO_PRESS = '0;
    localparam logic [ccd_pkg::ButtonWidth-1:0] PRESS_TENS = 5'b1 << ccd_pkg::BtnTens;
    localparam logic [ccd_pkg::ButtonWidth-1:0] PRESS_UNITS = 5'b1 << ccd_pkg::BtnUnits;
    localparam logic [ccd_pkg::ButtonWidth-1:0] PRESS_DECIMAL = 5'b1 << ccd_pkg::BtnDecimal;
    localparam logic [ccd_pkg::ButtonWidth-1:0] PRESS_TENTHS = 5'b1 << ccd_pkg::BtnTenths;
    localparam logic [ccd_pkg::ButtonWidth-1:0] PRESS_HUNDREDTHS =
        5'b1 << ccd_pkg::BtnHundredths;
    localparam logic [ccd_pkg::ButtonWidth-1:0] PRESS_ALL = '1;

    localparam int DENOM_KINDS = 9;
    localparam int MAX_LINES = 10;
    localparam int MAX_WAIT = 17;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_POLLS = 90;

    typedef struct packed {
        logic [ccd_pkg::PhaseWidth-1:0]  phase;
        logic [ccd_pkg::AmountWidth-1:0] whole;
        logic [ccd_pkg::AmountWidth-1:0] cent;
        logic [ccd_pkg::DenomWidth-1:0]  denom;
        logic [ccd_pkg::PiecesWidth-1:0] pieces;
        logic                            fin;
    } line_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ccd_pkg::AddrWidth-1:0] paddr = '0;
    logic [ccd_pkg::DataWidth-1:0] pwdata = '0;
    logic [ccd_pkg::DataWidth-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [ccd_pkg::ButtonWidth-1:0] buttons_pressed = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [ccd_pkg::PhaseWidth-1:0] phase;
    logic [ccd_pkg::AmountWidth-1:0] whole_part;
    logic [ccd_pkg::AmountWidth-1:0] cent_part;
    logic [ccd_pkg::DenomWidth-1:0] denom_index;
    logic [ccd_pkg::PiecesWidth-1:0] denom_count;
    logic last;

    // entry state as the block should hold it
    logic [ccd_pkg::DigitWidth-1:0] tens_q, units_q, tenths_q, hundredths_q;
    logic fraction_on;
    logic [ccd_pkg::CountWidth-1:0] idle_q, hold_q, confirm_q;
    logic [ccd_pkg::CountWidth-1:0] idle_limit_q, hold_limit_q, confirm_limit_q;

    line_t owed_lines[$];
    int breakdowns = 0;
    int polls_sent = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int send_cap = MAX_WAIT;
    int recv_cap = MAX_WAIT;

    coin_change_entry_dispenser DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .buttons_pressed(buttons_pressed),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .phase(phase),
        .whole_part(whole_part),
        .cent_part(cent_part),
        .denom_index(denom_index),
        .denom_count(denom_count),
        .last(last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [ccd_pkg::DigitWidth-1:0] wrap_digit(
        input logic [ccd_pkg::DigitWidth-1:0] d);
        return (d >= 4'd9) ? '0 : d + 1'b1;
    endfunction

    function automatic logic [ccd_pkg::CountWidth-1:0] count_up(
        input logic [ccd_pkg::CountWidth-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic line_t make_line(input logic [ccd_pkg::PhaseWidth-1:0] ph, input int w,
                                        input int c, input int idx, input int n,
                                        input logic fin);
        line_t l;
        l.phase = ph;
        l.whole = ccd_pkg::AmountWidth'(w);
        l.cent = ccd_pkg::AmountWidth'(c);
        l.denom = ccd_pkg::DenomWidth'(idx);
        l.pieces = ccd_pkg::PiecesWidth'(n);
        l.fin = fin;
        return l;
    endfunction

    function automatic void clear_entry();
        tens_q = '0;
        units_q = '0;
        tenths_q = '0;
        hundredths_q = '0;
        fraction_on = 1'b0;
        idle_q = '0;
        hold_q = '0;
        confirm_q = '0;
    endfunction

    // one poll: button action, hold check, display decision, idle count
    task automatic apply_poll(input logic [ccd_pkg::ButtonWidth-1:0] b);
        int whole_coins[4] = '{20, 10, 5, 1};
        int cent_coins[5] = '{50, 25, 10, 5, 1};
        int whole, cent, pieces, k, first_cent;
        logic empty;
        line_t batch[MAX_LINES];
        first_cent = int'(ccd_pkg::FirstCentDenom);
        whole = tens_q * 10 + units_q;
        cent = tenths_q * 10 + hundredths_q;
        empty = (whole == 0) && (cent == 0);
        if (idle_q < idle_limit_q || empty)
        begin
            if (b[ccd_pkg::BtnTens])
            begin
                tens_q = wrap_digit(tens_q);
                idle_q = '0;
            end
            else if (b[ccd_pkg::BtnUnits])
            begin
                units_q = wrap_digit(units_q);
                idle_q = '0;
            end
            else if (b[ccd_pkg::BtnDecimal])
            begin
                fraction_on = 1'b1;
                idle_q = '0;
            end
            else if (b[ccd_pkg::BtnTenths] && fraction_on)
            begin
                tenths_q = wrap_digit(tenths_q);
                idle_q = '0;
            end
            else if (b[ccd_pkg::BtnHundredths] && fraction_on)
            begin
                hundredths_q = wrap_digit(hundredths_q);
                idle_q = '0;
            end
        end
        hold_q = b[ccd_pkg::BtnDecimal] ? count_up(hold_q) : '0;
        if (hold_q > hold_limit_q)
            idle_q = '0;
        whole = tens_q * 10 + units_q;
        cent = tenths_q * 10 + hundredths_q;
        empty = (whole == 0) && (cent == 0);
        if (idle_q > idle_limit_q && !empty)
        begin
            confirm_q = count_up(confirm_q);
            if (confirm_q > confirm_limit_q)
            begin
                batch[0] = make_line(ccd_pkg::PhaseConfirmed, whole, cent, 0, 0, 1'b0);
                k = 1;
                for (int i = 0; i < DENOM_KINDS; i++)
                begin
                    if (i < first_cent)
                    begin
                        pieces = whole / whole_coins[i];
                        whole -= pieces * whole_coins[i];
                    end
                    else
                    begin
                        pieces = cent / cent_coins[i - first_cent];
                        cent -= pieces * cent_coins[i - first_cent];
                    end
                    if (pieces != 0)
                    begin
                        batch[k] = make_line(ccd_pkg::PhaseDenom, whole, cent, i, pieces,
                                             1'b0);
                        k++;
                    end
                end
                batch[k - 1].fin = 1'b1;
                for (int j = 0; j < k; j++)
                    owed_lines.push_back(batch[j]);
                clear_entry();
                breakdowns++;
                return;
            end
            owed_lines.push_back(make_line(ccd_pkg::PhaseConfirmed, whole, cent, 0, 0, 1'b1));
        end
        else
        begin
            confirm_q = '0;
            owed_lines.push_back(make_line(ccd_pkg::PhaseEntering, whole, cent, 0, 0, 1'b1));
        end
        idle_q = count_up(idle_q);
    endtask

    task automatic send_poll(input logic [ccd_pkg::ButtonWidth-1:0] b);
        int gap;
        gap = $urandom_range(send_cap, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        buttons_pressed <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        polls_sent++;
        apply_poll(b);
    endtask

    // hold off new requests until every owed result is out and the block has settled
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_lines.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [ccd_pkg::AddrWidth-1:0] addr,
                                  input logic [ccd_pkg::DataWidth-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (addr)
            REG_IDLE_LIMIT:    idle_limit_q = value[ccd_pkg::CountWidth-1:0];
            REG_HOLD_LIMIT:    hold_limit_q = value[ccd_pkg::CountWidth-1:0];
            REG_CONFIRM_LIMIT: confirm_limit_q = value[ccd_pkg::CountWidth-1:0];
            default:           ; // no register there, write dropped
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int idle_lim, input int hold_lim, input int confirm_lim);
        drain_results();
        write_register(REG_IDLE_LIMIT, idle_lim);
        write_register(REG_HOLD_LIMIT, hold_lim);
        write_register(REG_CONFIRM_LIMIT, confirm_lim);
    endtask

    task automatic poll_until_dispensed(input logic noisy, input int cap);
        int start, n;
        logic [ccd_pkg::ButtonWidth-1:0] b;
        start = breakdowns;
        n = 0;
        while (breakdowns == start && n < cap)
        begin
            b = NO_PRESS;
            if (noisy && $urandom_range(7, 0) == 0)
                b = ccd_pkg::ButtonWidth'($urandom_range(31, 0));
            send_poll(b);
            n++;
        end
    endtask

    function automatic logic [ccd_pkg::ButtonWidth-1:0] pick_press();
        if ($urandom_range(9, 0) < 7)
            return PRESS_HUNDREDTHS << $urandom_range(4, 0);
        return ccd_pkg::ButtonWidth'($urandom_range(31, 1));
    endfunction

    task automatic test_after_reset();
        // fraction buttons are locked at first, zero amount keeps input open
        send_poll(NO_PRESS);
        send_poll(PRESS_TENTHS);
        send_poll(PRESS_HUNDREDTHS);
        send_poll(PRESS_TENTHS | PRESS_HUNDREDTHS);
        send_poll(PRESS_ALL);
    endtask

    task automatic test_button_priority();
        configure(2, 1, 3);
        send_poll(PRESS_TENS | PRESS_UNITS);
        send_poll(PRESS_UNITS);
        send_poll(PRESS_TENTHS);
        send_poll(PRESS_DECIMAL);
        send_poll(PRESS_DECIMAL | PRESS_TENTHS);
        send_poll(PRESS_TENTHS);
        send_poll(PRESS_HUNDREDTHS);
        send_poll(PRESS_TENTHS | PRESS_HUNDREDTHS);
        // idle count reaches its limit, then goes past it
        repeat (3) send_poll(NO_PRESS);
        // held decimal reopens input
        repeat (4) send_poll(PRESS_DECIMAL);
        poll_until_dispensed(1'b0, 40);
    endtask

    task automatic test_odd_limits();
        // idle limit zero closes input once the amount is nonzero
        configure(0, 63, 63);
        send_poll(PRESS_TENS);
        send_poll(PRESS_UNITS);
        send_poll(PRESS_DECIMAL);
        send_poll(NO_PRESS);
        send_poll(NO_PRESS);
        drain_results();
        write_register(REG_UNUSED, $urandom);
        send_poll(PRESS_ALL);
        send_poll(NO_PRESS);
        drain_results();
        write_register(REG_CONFIRM_LIMIT, 1);
        poll_until_dispensed(1'b0, 10);
    endtask

    task automatic test_full_breakdown();
        // 99.94 needs every denomination
        configure(2, 1, 1);
        repeat (9) send_poll(PRESS_TENS);
        repeat (9) send_poll(PRESS_UNITS);
        send_poll(PRESS_DECIMAL);
        repeat (9) send_poll(PRESS_TENTHS);
        repeat (4) send_poll(PRESS_HUNDREDTHS);
        poll_until_dispensed(1'b0, 140);
    endtask

    task automatic test_held_decimal();
        // hold count runs into saturation while it keeps input reopened
        configure(1, 2, 3);
        send_poll(PRESS_TENS);
        repeat (64) send_poll(PRESS_DECIMAL);
        poll_until_dispensed(1'b0, 140);
    endtask

    task automatic test_random_entries();
        int start, seq;
        start = polls_sent;
        seq = 0;
        while (polls_sent - start < RANDOM_POLLS)
        begin
            if (seq % 3 == 0)
            begin
                if ($urandom_range(5, 0) == 0)
                    configure($urandom_range(60, 1), $urandom_range(60, 1),
                              $urandom_range(12, 1));
                else
                    configure($urandom_range(6, 1), $urandom_range(5, 1),
                              $urandom_range(6, 1));
            end
            send_cap = ($urandom_range(3, 0) == 0) ? 0 : MAX_WAIT;
            recv_cap = ($urandom_range(3, 0) == 0) ? 0 : MAX_WAIT;
            repeat ($urandom_range(12, 1)) send_poll(pick_press());
            poll_until_dispensed(1'b1, 140);
            seq++;
        end
    endtask

    initial
    begin : result_checker
        line_t want;
        int stall;
        wait (rst_n);
        forever
        begin
            stall = $urandom_range(recv_cap, 0);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (owed_lines.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = owed_lines.pop_front();
                if (phase !== want.phase)
                begin
                    $error("phase: expected %0d, got %0d", want.phase, phase);
                    mismatches++;
                end
                if (whole_part !== want.whole)
                begin
                    $error("whole_part: expected %0d, got %0d", want.whole, whole_part);
                    mismatches++;
                end
                if (cent_part !== want.cent)
                begin
                    $error("cent_part: expected %0d, got %0d", want.cent, cent_part);
                    mismatches++;
                end
                if (denom_index !== want.denom)
                begin
                    $error("denom_index: expected %0d, got %0d", want.denom, denom_index);
                    mismatches++;
                end
                if (denom_count !== want.pieces)
                begin
                    $error("denom_count: expected %0d, got %0d", want.pieces, denom_count);
                    mismatches++;
                end
                if (last !== want.fin)
                begin
                    $error("last: expected %0d, got %0d", want.fin, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        clear_entry();
        idle_limit_q = ccd_pkg::IdleLimitReset;
        hold_limit_q = ccd_pkg::HoldLimitReset;
        confirm_limit_q = ccd_pkg::ConfirmLimitReset;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_button_priority();
        test_odd_limits();
        test_full_breakdown();
        test_held_decimal();
        test_random_entries();
        drain_results();
        if (mismatches == 0 && owed_lines.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
